// ===== rtl/radio_frame_receive_classifier_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the radio frame receive classifier
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef RADIO_FRAME_RECEIVE_CLASSIFIER_TOP_MACROS_SVH
`define RADIO_FRAME_RECEIVE_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication: the consequent holds whenever the antecedent does.
`define RFRC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rfrc assertion failed");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define RFRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rfrc assertion failed");

`endif

// ===== rtl/rfrc_pkg.sv =====
// ---------------------------------------------------------------------------
// Radio frame receive classifier package
// Shared types, frame layout constants, verdict codes and the mod-19 helper.
// ---------------------------------------------------------------------------
package rfrc_pkg;

    // Frame length limit; bytes at or past this position are ignored.
    localparam int FRAME_LIMIT = 256;
    localparam int POS_W       = $clog2(FRAME_LIMIT + 1);

    // Byte positions within a frame.
    localparam int POS_DEST_LO   = 0;
    localparam int POS_DEST_HI   = 1;
    localparam int POS_SRC_LO    = 2;
    localparam int POS_SRC_HI    = 3;
    localparam int POS_HEADER    = 4;
    localparam int POS_CHECK     = 5;
    localparam int PAYLOAD_START = 6;

    // Header codes.
    localparam logic [7:0] HDR_ACK     = 8'hff;
    localparam logic [7:0] HDR_BCAST   = 8'haa;
    localparam logic [7:0] HDR_ASSIGN2 = 8'hfd;
    localparam logic [7:0] HDR_ASSIGN3 = 8'hfe;

    // Reset values of the address registers.
    localparam logic [15:0] PRIMARY_ID_RST = 16'hfeed;
    localparam logic [15:0] SECOND_ID_RST  = 16'hbead;
    localparam logic [15:0] THIRD_ID_RST   = 16'hcafe;
    localparam logic [7:0]  ACK_CHECK_RST  = 8'h00;

    // Payload checksum modulus and its reciprocal (27 / 2**9 ~ 1 / 19).
    localparam int SUM_MOD     = 19;
    localparam int RECIP_MUL   = 27;
    localparam int RECIP_SHIFT = 9;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PRIMARY_ID = 2'd0,
        CFG_SECOND_ID  = 2'd1,
        CFG_THIRD_ID   = 2'd2,
        CFG_ACK_CHECK  = 2'd3
    } cfg_index_t;

    // Verdict codes.
    typedef enum logic [2:0] {
        VERDICT_REJECT  = 3'd0,
        VERDICT_DATA_OK = 3'd1,
        VERDICT_ACK_OK  = 3'd2,
        VERDICT_BCAST   = 3'd3,
        VERDICT_ASSIGN2 = 3'd4,
        VERDICT_ASSIGN3 = 3'd5
    } verdict_t;

    // One received byte and its end-of-frame mark.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_item_t;

    // Fields gathered over one frame.
    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] source;
        logic [7:0]  header;
        logic [7:0]  check;
        logic [4:0]  residue;
    } frame_fields_t;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] primary_id;
        logic [15:0] second_id;
        logic [15:0] third_id;
        logic [7:0]  ack_check;
    } cfg_regs_t;

    // Adds one byte to a running residue modulo 19. The quotient of the byte
    // by 19 comes from a reciprocal multiply, which is exact for 8-bit values.
    function automatic logic [4:0] mod19_add(input logic [4:0] residue,
                                             input logic [7:0] b);
        logic [12:0] prod;
        logic [3:0]  quot;
        logic [7:0]  rem;
        logic [5:0]  sum;
        prod = 13'(b) * 13'(RECIP_MUL);
        quot = prod[12:RECIP_SHIFT];
        rem  = b - 8'(8'(quot) * 8'(SUM_MOD));
        sum  = 6'(residue) + 6'(rem[4:0]);
        if (sum >= 6'(SUM_MOD)) begin
            sum = sum - 6'(SUM_MOD);
        end
        return sum[4:0];
    endfunction

endpackage

// ===== rtl/rfrc_input_stage.sv =====
// ---------------------------------------------------------------------------
// Input register
// Captures one byte transaction and holds it until the parser takes it.
// ---------------------------------------------------------------------------
module rfrc_input_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rfrc_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output rfrc_pkg::in_item_t item
);
    import rfrc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register frees up in the same cycle that its item moves on.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/rfrc_frame_parser.sv =====
// ---------------------------------------------------------------------------
// Frame parser
// Tracks the byte position and gathers address, header, check and payload sum.
// ---------------------------------------------------------------------------
module rfrc_frame_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  rfrc_pkg::in_item_t      item,
    output rfrc_pkg::frame_fields_t fields_next
);
    import rfrc_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    frame_fields_t    fields_reg;
    logic             in_payload;

    // The header gives how many payload bytes take part in the sum.
    assign in_payload = (pos_reg >= POS_W'(PAYLOAD_START)) &&
                        (16'(pos_reg - POS_W'(PAYLOAD_START)) < 16'(fields_reg.header));

    // Fold the current byte into the frame fields.
    always_comb begin
        fields_next = fields_reg;
        pos_next    = pos_reg;
        if (pos_reg < POS_W'(FRAME_LIMIT)) begin
            case (pos_reg)
                POS_W'(POS_DEST_LO): fields_next.dest[7:0]    = item.rx_byte;
                POS_W'(POS_DEST_HI): fields_next.dest[15:8]   = item.rx_byte;
                POS_W'(POS_SRC_LO):  fields_next.source[7:0]  = item.rx_byte;
                POS_W'(POS_SRC_HI):  fields_next.source[15:8] = item.rx_byte;
                POS_W'(POS_HEADER):  fields_next.header       = item.rx_byte;
                POS_W'(POS_CHECK):   fields_next.check        = item.rx_byte;
                default: begin
                    if (in_payload) begin
                        fields_next.residue = mod19_add(fields_reg.residue, item.rx_byte);
                    end
                end
            endcase
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // Frame state; an end mark clears everything for the next frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            fields_reg <= '0;
        end else if (advance) begin
            if (item.frame_end) begin
                pos_reg    <= '0;
                fields_reg <= '0;
            end else begin
                pos_reg    <= pos_next;
                fields_reg <= fields_next;
            end
        end
    end

endmodule

// ===== rtl/rfrc_verdict.sv =====
// ---------------------------------------------------------------------------
// Verdict stage
// Judges a finished frame, updates the own address and holds the result.
// ---------------------------------------------------------------------------
module rfrc_verdict (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  rfrc_pkg::frame_fields_t fields,
    input  rfrc_pkg::cfg_regs_t     cfg,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2:0]              m_verdict,
    output logic [15:0]             m_peer_address,
    output logic [15:0]             m_node_address,
    output logic [15:0]             own_address
);
    import rfrc_pkg::*;

    logic        out_valid_reg;
    verdict_t    verdict_reg;
    logic [15:0] peer_reg;
    logic [15:0] node_reg;
    logic [15:0] own_reg;
    logic [15:0] own_next;
    verdict_t    verdict_next;

    // Classification of a completed frame.
    always_comb begin
        own_next     = own_reg;
        verdict_next = VERDICT_REJECT;
        if (fields.dest == own_reg) begin
            case (fields.header)
                HDR_ACK: begin
                    verdict_next = (fields.check == cfg.ack_check) ? VERDICT_ACK_OK
                                                                   : VERDICT_REJECT;
                end
                HDR_BCAST: begin
                    verdict_next = (own_reg == cfg.primary_id) ? VERDICT_BCAST
                                                               : VERDICT_REJECT;
                end
                HDR_ASSIGN2: begin
                    verdict_next = VERDICT_ASSIGN2;
                    own_next     = cfg.second_id;
                end
                HDR_ASSIGN3: begin
                    verdict_next = VERDICT_ASSIGN3;
                    own_next     = cfg.third_id;
                end
                default: begin
                    verdict_next = (8'(fields.residue) == fields.check) ? VERDICT_DATA_OK
                                                                        : VERDICT_REJECT;
                end
            endcase
        end
    end

    // Own address and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg       <= PRIMARY_ID_RST;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                own_reg <= own_next;
            end
            out_valid_reg <= load || (out_valid_reg && !m_ready);
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            verdict_reg <= verdict_next;
            peer_reg    <= fields.source;
            node_reg    <= own_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_verdict      = verdict_reg;
    assign m_peer_address = peer_reg;
    assign m_node_address = node_reg;
    assign own_address    = own_reg;

endmodule

// ===== rtl/radio_frame_receive_classifier_top.sv =====
// ---------------------------------------------------------------------------
// Radio frame receive classifier
// Parses received frame bytes and gives one verdict per frame.
// ---------------------------------------------------------------------------
// The block accepts one byte per clock cycle and gives one result transaction
// for each byte marked as frame end; other bytes give no result. A result
// becomes valid once its end byte has left the input register and the verdict
// stage has registered the result; it is held there until it is taken.
// Bytes keep flowing while a result waits; only a second frame end stalls
// until the pending result is taken.
// Configuration writes take effect at once and belong in idle periods.
module radio_frame_receive_classifier_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [15:0] m_peer_address,
    output logic [15:0] m_node_address
);
    import rfrc_pkg::*;

    `include "radio_frame_receive_classifier_top_macros.svh"

    cfg_regs_t     cfg_reg;
    in_item_t      s_item;
    in_item_t      item;
    logic          item_valid;
    logic          advance;
    logic          load;
    frame_fields_t fields_next;
    logic [15:0]   own_address;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.primary_id <= PRIMARY_ID_RST;
            cfg_reg.second_id  <= SECOND_ID_RST;
            cfg_reg.third_id   <= THIRD_ID_RST;
            cfg_reg.ack_check  <= ACK_CHECK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_PRIMARY_ID: cfg_reg.primary_id <= cfg_wdata;
                CFG_SECOND_ID:  cfg_reg.second_id  <= cfg_wdata;
                CFG_THIRD_ID:   cfg_reg.third_id   <= cfg_wdata;
                CFG_ACK_CHECK:  cfg_reg.ack_check  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // A byte moves on unless it ends a frame while a result is still pending.
    assign advance = item_valid && (!item.frame_end || !m_valid || m_ready);
    assign load    = advance && item.frame_end;

    assign s_item.rx_byte   = s_rx_byte;
    assign s_item.frame_end = s_frame_end;

    rfrc_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rfrc_frame_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (item),
        .fields_next (fields_next)
    );

    rfrc_verdict u_verdict (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .fields         (fields_next),
        .cfg            (cfg_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_peer_address (m_peer_address),
        .m_node_address (m_node_address),
        .own_address    (own_address)
    );

    // A frame end that moves on always leaves a result behind.
    `RFRC_ASSERT_NEXT(a_end_gives_result, aclk, aresetn, load, m_valid)
    // A pending result is never overwritten by the next frame end.
    `RFRC_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_valid && !m_ready, !load)
    // The own address only changes when a frame is judged.
    `RFRC_ASSERT_NEXT(a_own_addr_hold, aclk, aresetn, !load, $stable(own_address))

endmodule
